FILE: rtl/fbd_pkg.sv
// ---------------------------------------------------------------------------
// fbd_pkg
// Shared types and constants for the five-button debounce and chord block.
// ---------------------------------------------------------------------------
package fbd_pkg;

  // buttons: four directions in priority order, then enter
  localparam int NUM_BTN   = 5;
  localparam int NUM_DIR   = 4;
  localparam int ENTER_IDX = 4;

  localparam int CODE_W = 4;

  // event codes
  localparam logic [CODE_W-1:0] CODE_DOWN       = 4'd0;
  localparam logic [CODE_W-1:0] CODE_ENTER      = 4'd4;
  localparam logic [CODE_W-1:0] CODE_WITH_ENTER = 4'd5;

  // config register
  localparam int               CFG_W          = 16;
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } event_t;

  // merge stage result for one tick
  typedef struct packed {
    logic [1:0]         count;
    event_t             ev0;
    event_t             ev1;
    logic [NUM_BTN-1:0] stop;
  } merge_out_t;

endpackage

FILE: rtl/five_button_debounce_combo.sv
// ---------------------------------------------------------------------------
// five_button_debounce_combo
// Debounces five active-low buttons and reports direction, enter and chords.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per tick, s_tdata[4:0] = down, up, left, right,
//   enter raw levels (0 = pressed). Each accepted word advances all five
//   debounce timers by one tick.
//   Master stream: m_tdata[3:0] = event code, m_tlast marks the final event
//   of a tick. A tick gives zero, one or two events.
//   Config: cfg_we writes cfg_wdata into the debounce length (reset 50);
//   write only while idle.
// Timing: with the queue empty, events of a tick are offered on the master
//   side in the cycle after the tick word is accepted.
// Throughput: one tick word per cycle while ticks give at most one event;
//   the five timer lanes and the merge stage work out a tick's events
//   combinationally. Ticks that give two events are slowed down by the
//   one-word master side. s_tready drops while the four-word output
//   queue lacks room for two words, so a stalled receiver stalls the input
//   after two or three ticks that produce events.
// Reset: timers go idle, last levels read as released, queue empties.
// ---------------------------------------------------------------------------
module five_button_debounce_combo #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // down, up, left, right, enter, pad
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // event_code[3:0], pad
  output logic                      m_tlast,
  input  logic                      cfg_we,
  input  logic [fbd_pkg::CFG_W-1:0] cfg_wdata
);

  logic [fbd_pkg::CFG_W-1:0]   debounce_ticks;
  logic [COUNT_WIDTH-1:0]      load;
  logic                        tick;
  logic [fbd_pkg::NUM_BTN-1:0] levels;
  logic [fbd_pkg::NUM_BTN-1:0] pressed;
  fbd_pkg::merge_out_t         merged;
  fbd_pkg::event_t             head;
  logic                        room;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= fbd_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_ticks <= cfg_wdata;
    end
  end

  // saturate the debounce length to the counter width
  generate
    if (COUNT_WIDTH >= fbd_pkg::CFG_W) begin : g_wide
      assign load = COUNT_WIDTH'(debounce_ticks);
    end else begin : g_narrow
      localparam logic [fbd_pkg::CFG_W-1:0] CountMax =
        fbd_pkg::CFG_W'((64'd1 << COUNT_WIDTH) - 64'd1);
      assign load = (debounce_ticks > CountMax) ? '1
                                                : debounce_ticks[COUNT_WIDTH-1:0];
    end
  endgenerate

  assign s_tready = room;
  assign tick     = s_tvalid && room;
  assign levels   = s_tdata[fbd_pkg::NUM_BTN-1:0];

  // one timer lane per button
  generate
    for (genvar g = 0; g < fbd_pkg::NUM_BTN; g++) begin : g_lane
      fbd_lane #(
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_lane (
        .clk    (clk),
        .rst    (rst),
        .tick   (tick),
        .level  (levels[g]),
        .load   (load),
        .stop   (merged.stop[g]),
        .pressed(pressed[g])
      );
    end
  endgenerate

  // event priority and chord pairing
  fbd_merge u_merge (
    .pressed(pressed),
    .levels (levels),
    .result (merged)
  );

  // output queue
  fbd_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push_n(merged.count),
    .ev0   (merged.ev0),
    .ev1   (merged.ev1),
    .room  (room),
    .valid (m_tvalid),
    .ready (m_tready),
    .head  (head)
  );

  assign m_tdata = {4'b0000, head.code};
  assign m_tlast = head.last;

endmodule

FILE: rtl/fbd_lane.sv
// ---------------------------------------------------------------------------
// fbd_lane
// Debounce timer for one button: change detect, countdown, expiry sample.
// ---------------------------------------------------------------------------
module fbd_lane #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,     // word accepted this cycle
  input  logic                   level,    // raw level, 0 = pressed
  input  logic [COUNT_WIDTH-1:0] load,     // saturated debounce count
  input  logic                   stop,     // chord logic stops this timer
  output logic                   pressed   // expired with level low
);

  logic                   prev_level;
  logic                   running;
  logic [COUNT_WIDTH-1:0] remaining;

  logic                   start;
  logic                   run0;
  logic [COUNT_WIDTH-1:0] rem0;
  logic                   expire;

  // start an idle timer on a level change, then check for expiry
  always_comb begin
    start   = tick && (level != prev_level) && !running;
    run0    = running || start;
    rem0    = start ? load : remaining;
    expire  = tick && run0 && (rem0 <= COUNT_WIDTH'(1));
    pressed = expire && !level;
  end

  // timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b1;
      running    <= 1'b0;
      remaining  <= '0;
    end else if (tick) begin
      prev_level <= level;
      if (expire || stop) begin
        running   <= 1'b0;
        remaining <= '0;
      end else if (run0) begin
        running   <= 1'b1;
        remaining <= rem0 - COUNT_WIDTH'(1);
      end
    end
  end

endmodule

FILE: rtl/fbd_merge.sv
// ---------------------------------------------------------------------------
// fbd_merge
// Combines lane expiries into direction, chord and enter events.
// ---------------------------------------------------------------------------
module fbd_merge (
  input  logic [fbd_pkg::NUM_BTN-1:0] pressed,
  input  logic [fbd_pkg::NUM_BTN-1:0] levels,
  output fbd_pkg::merge_out_t         result
);

  logic                          dir_found;
  logic [fbd_pkg::CODE_W-1:0]    dir_code;
  logic                          low_found;
  logic [fbd_pkg::CODE_W-1:0]    ent_code;
  logic                          enter_low;
  logic                          enter_hit;
  fbd_pkg::event_t               dir_ev;
  fbd_pkg::event_t               ent_ev;

  always_comb begin
    enter_low = !levels[fbd_pkg::ENTER_IDX];
    enter_hit = pressed[fbd_pkg::ENTER_IDX];
    result    = '0;

    // first pressed direction, with enter if enter is held low
    dir_found = 1'b0;
    dir_code  = fbd_pkg::CODE_DOWN;
    for (int i = 0; i < fbd_pkg::NUM_DIR; i++) begin
      if (!dir_found && pressed[i]) begin
        dir_found = 1'b1;
        dir_code  = enter_low ? fbd_pkg::CODE_WITH_ENTER + fbd_pkg::CODE_W'(i)
                              : fbd_pkg::CODE_DOWN + fbd_pkg::CODE_W'(i);
      end
    end
    if (dir_found && enter_low) begin
      result.stop[fbd_pkg::ENTER_IDX] = 1'b1;
    end

    // pressed enter pairs with first low direction level
    low_found = 1'b0;
    ent_code  = fbd_pkg::CODE_ENTER;
    for (int i = 0; i < fbd_pkg::NUM_DIR; i++) begin
      if (!low_found && !levels[i]) begin
        low_found = 1'b1;
        ent_code  = fbd_pkg::CODE_WITH_ENTER + fbd_pkg::CODE_W'(i);
        if (enter_hit) begin
          result.stop[i] = 1'b1;
        end
      end
    end

    dir_ev.code = dir_code;
    dir_ev.last = !enter_hit;
    ent_ev.code = ent_code;
    ent_ev.last = 1'b1;

    // order the words: direction first, then enter
    if (dir_found) begin
      result.ev0   = dir_ev;
      result.ev1   = ent_ev;
      result.count = enter_hit ? 2'd2 : 2'd1;
    end else begin
      result.ev0   = ent_ev;
      result.ev1   = ent_ev;
      result.count = enter_hit ? 2'd1 : 2'd0;
    end
  end

endmodule

FILE: rtl/fbd_out_fifo.sv
// ---------------------------------------------------------------------------
// fbd_out_fifo
// Small output queue: takes up to two event words a cycle, sends one.
// ---------------------------------------------------------------------------
module fbd_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_n,
  input  fbd_pkg::event_t ev0,
  input  fbd_pkg::event_t ev1,
  output logic            room,    // space for two words
  output logic            valid,
  input  logic            ready,
  output fbd_pkg::event_t head
);

  fbd_pkg::event_t                   mem [fbd_pkg::FIFO_DEPTH];
  logic [fbd_pkg::FIFO_PTR_W-1:0]    wr_ptr;
  logic [fbd_pkg::FIFO_PTR_W-1:0]    rd_ptr;
  logic [fbd_pkg::FIFO_CNT_W-1:0]    count;
  logic                              pop;

  assign valid = (count != '0);
  assign room  = (count <= fbd_pkg::FIFO_CNT_W'(fbd_pkg::FIFO_DEPTH - 2));
  assign pop   = valid && ready;
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= ev0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + fbd_pkg::FIFO_PTR_W'(1)] <= ev1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + fbd_pkg::FIFO_PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + fbd_pkg::FIFO_PTR_W'(1);
      end
      count <= count + fbd_pkg::FIFO_CNT_W'(push_n) - fbd_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the five-button debounce and chord block. Each tick word
// is fed into a local debounce/chord predictor, and every event word
// on the master side is checked against the oldest predicted event.
// Directed ticks cover the debounce extremes, the priority and chord
// cases and a receiver hold-off. Random press/release gestures with
// bounce follow, under sender idle and receiver stall patterns.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int BTN_DOWN  = 0;
  localparam int BTN_UP    = 1;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_RIGHT = 3;

  localparam logic [fbd_pkg::NUM_BTN-1:0] ALL_RELEASED = '1;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LAT_PAUSE      = 4;
  localparam int RANDOM_TICKS   = 1560;
  localparam int HOLD_OFF       = 80;

  // DUT signals
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata = {3'b000, ALL_RELEASED};
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [7:0]                m_tdata;
  logic                      m_tlast;
  logic                      cfg_we = 1'b0;
  logic [fbd_pkg::CFG_W-1:0] cfg_wdata = '0;

  // traffic shaping
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;

  // predictor state
  logic [fbd_pkg::CFG_W-1:0]   db_ticks = fbd_pkg::DEBOUNCE_RESET;
  logic [fbd_pkg::NUM_BTN-1:0] last_lv  = '1;
  logic [fbd_pkg::CFG_W-1:0]   tmr_left [fbd_pkg::NUM_BTN];
  logic [fbd_pkg::NUM_BTN-1:0] tmr_busy = '0;

  fbd_pkg::event_t pending_events[$];

  logic [fbd_pkg::NUM_BTN-1:0] cur_lv = '1;
  int n_ticks  = 0;
  int n_events = 0;
  int errors   = 0;
  int idle_cycles = 0;

  five_button_debounce_combo u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < fbd_pkg::NUM_BTN; i++) tmr_left[i] = '0;
  end

  // debounce and chord prediction for one accepted tick
  task automatic predict_tick(input logic [fbd_pkg::NUM_BTN-1:0] lv);
    logic [fbd_pkg::NUM_BTN-1:0] hit;
    logic [fbd_pkg::CODE_W-1:0]  codes[$];
    logic [fbd_pkg::CODE_W-1:0]  code;
    fbd_pkg::event_t             ev;
    bit                          found;
    hit = '0;
    // level change arms an idle timer
    for (int i = 0; i < fbd_pkg::NUM_BTN; i++) begin
      if (lv[i] != last_lv[i]) begin
        last_lv[i] = lv[i];
        if (!tmr_busy[i]) begin
          tmr_busy[i] = 1'b1;
          tmr_left[i] = db_ticks;
        end
      end
    end
    // count down; sample on expiry (zero length acts as one)
    for (int i = 0; i < fbd_pkg::NUM_BTN; i++) begin
      if (tmr_busy[i]) begin
        if (tmr_left[i] <= 1) begin
          if (!lv[i]) hit[i] = 1'b1;
          tmr_busy[i] = 1'b0;
          tmr_left[i] = '0;
        end else begin
          tmr_left[i] = tmr_left[i] - 1'b1;
        end
      end
    end
    // first pressed direction, plain or with enter
    found = 1'b0;
    for (int i = 0; i < fbd_pkg::NUM_DIR; i++) begin
      if (hit[i] && !found) begin
        found = 1'b1;
        if (!lv[fbd_pkg::ENTER_IDX]) begin
          tmr_busy[fbd_pkg::ENTER_IDX] = 1'b0;
          tmr_left[fbd_pkg::ENTER_IDX] = '0;
          codes.push_back(fbd_pkg::CODE_WITH_ENTER + fbd_pkg::CODE_W'(i));
        end else begin
          codes.push_back(fbd_pkg::CODE_DOWN + fbd_pkg::CODE_W'(i));
        end
      end
    end
    // enter pairs with the first held direction
    if (hit[fbd_pkg::ENTER_IDX]) begin
      code  = fbd_pkg::CODE_ENTER;
      found = 1'b0;
      for (int i = 0; i < fbd_pkg::NUM_DIR; i++) begin
        if (!lv[i] && !found) begin
          found = 1'b1;
          tmr_busy[i] = 1'b0;
          tmr_left[i] = '0;
          code = fbd_pkg::CODE_WITH_ENTER + fbd_pkg::CODE_W'(i);
        end
      end
      codes.push_back(code);
    end
    for (int k = 0; k < codes.size(); k++) begin
      ev.code = codes[k];
      ev.last = (k == codes.size() - 1);
      pending_events.push_back(ev);
    end
  endtask

  // offer one tick word, with random sender gaps
  task automatic send_tick(input logic [fbd_pkg::NUM_BTN-1:0] lv);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, lv};
    do @(posedge clk); while (!s_tready);
    predict_tick(lv);
    cur_lv  = lv;
    n_ticks = n_ticks + 1;
  endtask

  // stop sending and let every predicted event arrive
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (LAT_PAUSE) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [fbd_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    db_ticks = value;
  endtask

  // walk to a level pattern with some bounce, then hold it
  task automatic move_to(input logic [fbd_pkg::NUM_BTN-1:0] target, input int hold);
    logic [fbd_pkg::NUM_BTN-1:0] diff;
    diff = cur_lv ^ target;
    repeat ($urandom_range(0, 2))
      send_tick(target ^ (diff & fbd_pkg::NUM_BTN'($urandom_range(0, 31))));
    repeat (hold + $urandom_range(0, 2)) send_tick(target);
  endtask

  // ---- tests --------------------------------------------------------------

  // reset length of 50 ticks
  task automatic test_default_debounce();
    repeat (fbd_pkg::DEBOUNCE_RESET) send_tick(ALL_RELEASED & ~(5'b1 << BTN_DOWN));
    repeat (fbd_pkg::DEBOUNCE_RESET) send_tick(ALL_RELEASED);
  endtask

  // every key alone, zero length acting as one
  task automatic test_single_keys();
    set_debounce('0);
    for (int b = 0; b < fbd_pkg::NUM_BTN; b++) begin
      send_tick(ALL_RELEASED & ~(5'b1 << b));
      send_tick(ALL_RELEASED);
    end
  endtask

  // direction priority, chord pairing and two events in one tick
  task automatic test_chords();
    set_debounce(16'd1);
    send_tick(5'b1 << fbd_pkg::ENTER_IDX);
    send_tick(ALL_RELEASED);
    send_tick('0);
    send_tick(ALL_RELEASED);
    send_tick(ALL_RELEASED & ~(5'b1 << fbd_pkg::ENTER_IDX));
    send_tick(ALL_RELEASED & ~(5'b1 << fbd_pkg::ENTER_IDX) & ~(5'b1 << BTN_LEFT));
    send_tick(ALL_RELEASED & ~(5'b1 << BTN_LEFT));
    send_tick(ALL_RELEASED);
    send_tick(ALL_RELEASED & ~(5'b1 << BTN_RIGHT));
    send_tick(ALL_RELEASED & ~(5'b1 << BTN_RIGHT) & ~(5'b1 << fbd_pkg::ENTER_IDX));
    send_tick(ALL_RELEASED & ~(5'b1 << BTN_UP));
    send_tick(ALL_RELEASED);
  endtask

  // full-scale length; the long down timer is cleared by an enter chord
  task automatic test_long_debounce();
    set_debounce('1);
    send_tick(ALL_RELEASED);
    send_tick(ALL_RELEASED & ~(5'b1 << BTN_DOWN));
    send_tick(ALL_RELEASED & ~(5'b1 << BTN_DOWN));
    set_debounce(16'd2);
    send_tick(ALL_RELEASED & ~(5'b1 << BTN_DOWN) & ~(5'b1 << fbd_pkg::ENTER_IDX));
    send_tick(ALL_RELEASED & ~(5'b1 << BTN_DOWN) & ~(5'b1 << fbd_pkg::ENTER_IDX));
    send_tick(ALL_RELEASED);
    send_tick(ALL_RELEASED);
  endtask

  // receiver holds off while every tick makes an event; input must stall
  task automatic test_backpressure();
    set_debounce(16'd1);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = HOLD_OFF;
    for (int k = 0; k < 16; k++) begin
      if (k[0]) send_tick(ALL_RELEASED & ~(5'b1 << BTN_UP));
      else      send_tick(ALL_RELEASED & ~(5'b1 << BTN_DOWN));
    end
    send_tick(ALL_RELEASED);
    wait_drained();
  endtask

  // random gestures: presses, chords, bounce and raw noise
  task automatic test_random(input logic [fbd_pkg::CFG_W-1:0] d, input int src,
                             input int sink, input int n);
    int                          start;
    int                          span;
    int                          dir;
    logic [fbd_pkg::NUM_BTN-1:0] mask;
    set_debounce(d);
    src_idle_pct   = src;
    sink_stall_pct = sink;
    span  = (d == 0) ? 1 : int'(d);
    start = n_ticks;
    while (n_ticks - start < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 6))
            send_tick(fbd_pkg::NUM_BTN'($urandom_range(0, 31)));
        end
        2: begin
          // staggered chord: one key first, then the other
          dir = $urandom_range(0, fbd_pkg::NUM_DIR - 1);
          mask = $urandom_range(0, 1) ? (5'b1 << fbd_pkg::ENTER_IDX) : (5'b1 << dir);
          move_to(cur_lv & ~mask, span);
          move_to(cur_lv & ~(5'b1 << dir) & ~(5'b1 << fbd_pkg::ENTER_IDX), span);
          move_to(ALL_RELEASED, span);
        end
        default: begin
          if ($urandom_range(0, 1)) mask = 5'b1 << $urandom_range(0, fbd_pkg::NUM_BTN - 1);
          else                      mask = fbd_pkg::NUM_BTN'($urandom_range(1, 31));
          move_to(cur_lv & ~mask, span);
          move_to(ALL_RELEASED, span);
        end
      endcase
    end
  endtask

  // ---- receiver, checker, watchdog ----------------------------------------

  // random stalls, plus the long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // compare each event word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event word: code %0d last %0b",
                 $time, m_tdata[fbd_pkg::CODE_W-1:0], m_tlast);
        errors = errors + 1;
      end else begin
        if (m_tdata[fbd_pkg::CODE_W-1:0] !== pending_events[0].code) begin
          $display("%0t: event code mismatch: expected %0d, actual %0d",
                   $time, pending_events[0].code, m_tdata[fbd_pkg::CODE_W-1:0]);
          errors = errors + 1;
        end
        if (m_tlast !== pending_events[0].last) begin
          $display("%0t: tlast mismatch: expected %0b, actual %0b",
                   $time, pending_events[0].last, m_tlast);
          errors = errors + 1;
        end
        void'(pending_events.pop_front());
        n_events = n_events + 1;
      end
    end
  end

  // no word moving on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d events pending", $time,
               pending_events.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- sequence -----------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_debounce();
    test_single_keys();
    test_chords();
    test_long_debounce();
    test_backpressure();
    test_random(16'd1, 0,  0,  RANDOM_TICKS / 4);
    test_random(16'd3, 45, 0,  RANDOM_TICKS / 4);
    test_random(16'd2, 0,  45, RANDOM_TICKS / 4);
    test_random(16'd5, 10, 10, RANDOM_TICKS / 4);

    wait_drained();
    if (pending_events.size() != 0) begin
      $display("%0t: %0d events never arrived", $time, pending_events.size());
      errors = errors + 1;
    end
    $display("Ran %0d ticks, %0d events checked; debounce 0 to 65535,", n_ticks, n_events);
    $display("chords and priority, bounce, sender gaps, receiver stalls and hold-off.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
